// ===== rtl/multi_channel_periodic_timer_unit_assert.svh =====
// assertion macros for the periodic timer unit
// expects clk_i and rst_ni in the including module
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_UNIT_ASSERT_SVH

// same-cycle implication
`define MCTU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("periodic timer assertion failed");

// next-cycle implication
`define MCTU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("periodic timer assertion failed");

`endif

// ===== rtl/mctu_pkg.sv =====
// shared types and codes for the periodic timer unit
// no dependencies
package mctu_pkg;

  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PERIOD_W = 32;

  localparam logic [31:0] WAKE_DEFAULT_RST = 32'd100;

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_UNREGISTER = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } state_e;

endpackage

// ===== rtl/multi_channel_periodic_timer_unit.sv =====
// multi_channel_periodic_timer_unit: table of periodic timer channels, depends on mctu_pkg,
// mctu_ram and multi_channel_periodic_timer_unit_assert.svh.
// Register and unregister items (mode 0 and 1) are carried out when accepted and give
// no result. A tick item (mode 2) is accepted, then each channel in index order goes
// through the shared elapsed-time subtract and compare unit, fed by the period and
// last-fire rams one entry per cycle while no fired item waits for the output register,
// then the report is loaded. A tick gives one fired item per armed due channel in index
// order, then a report item with last set carrying the next wake interval. While a fired
// or report item waits for the output register to free up, the scan or report holds.
// The port is not ready while a tick is in progress. The single register, the wake
// interval reported when none is armed, sits at every apb address, pready is always high.
`include "multi_channel_periodic_timer_unit_assert.svh"

module multi_channel_periodic_timer_unit
  import mctu_pkg::*;
#(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [3:0]          subject_i,
  input  logic [31:0]         interval_i,
  input  logic [31:0]         now_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [3:0]          subject_res_o,
  output logic [31:0]         wake_interval_o,
  output logic                last_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CmpW = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

  state_e state_q, state_d;

  logic [31:0]           default_q;
  logic [CHANNELS-1:0]   armed_q, armed_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [31:0]           next_q, next_d;
  logic                  any_q, any_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [3:0]  subj_q, subj_d;
  logic [31:0] nxt_q, nxt_d;
  logic        last_q, last_d;

  logic                  in_fire, out_free, subj_ok, idx_last, step, due, load_fire;
  logic [7:0]            subj8, idx8;
  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_tw, elapsed;
  logic [IdxW-1:0]       subj_idx;
  logic [CmpW-1:0]       elapsed_c, period_c, left_c;
  logic [31:0]           cand;

  logic                  ram_re, per_we, lft_we;
  logic [IdxW-1:0]       ram_raddr, lft_waddr;
  logic [TIME_WIDTH-1:0] lft_wdata, lft_rd;
  logic [PERIOD_W-1:0]   per_rd;

  // apb register
  assign pready = 1'b1;
  assign prdata = default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= WAKE_DEFAULT_RST;
    end else if (psel && penable && pwrite && pready) begin
      default_q <= pwdata;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign now_ext  = {32'b0, now_i};
  assign now_tw   = now_ext[TIME_WIDTH-1:0];
  assign subj8    = {4'b0, subject_i};
  assign subj_idx = subj8[IdxW-1:0];
  assign subj_ok  = {5'b0, subject_i} < 9'(CHANNELS);
  assign idx8     = 8'(idx_q);
  assign idx_last = (idx_q == IdxW'(CHANNELS - 1));

  // shared elapsed-time unit
  assign elapsed   = now_q - lft_rd;
  assign elapsed_c = CmpW'(elapsed);
  assign period_c  = CmpW'(per_rd);
  assign left_c    = period_c - elapsed_c;
  assign due       = elapsed_c >= period_c;
  assign cand      = due ? per_rd : left_c[31:0];

  assign load_fire = armed_q[idx_q] && due;
  assign step      = !load_fire || out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && mode_i == MODE_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && idx_last) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    armed_d     = armed_q;
    idx_d       = idx_q;
    now_d       = now_q;
    next_d      = next_q;
    any_d       = any_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    subj_d      = subj_q;
    nxt_d       = nxt_q;
    last_d      = last_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    per_we      = 1'b0;
    lft_we      = 1'b0;
    lft_waddr   = subj_idx;
    lft_wdata   = now_tw;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (mode_i)
            MODE_REGISTER: begin
              if (subj_ok && !armed_q[subj_idx]) begin
                armed_d[subj_idx] = 1'b1;
                per_we            = 1'b1;
                lft_we            = 1'b1;
              end
            end
            MODE_UNREGISTER: begin
              if (subj_ok) begin
                armed_d[subj_idx] = 1'b0;
              end
            end
            MODE_TICK: begin
              ram_re = 1'b1;
              idx_d  = '0;
              now_d  = now_tw;
              any_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (armed_q[idx_q]) begin
            any_d = 1'b1;
            if (!any_q || cand < next_q) begin
              next_d = cand;
            end
          end
          if (load_fire) begin
            lft_we      = 1'b1;
            lft_waddr   = idx_q;
            lft_wdata   = now_q;
            out_valid_d = 1'b1;
            kind_d      = KIND_FIRED;
            subj_d      = idx8[3:0];
            nxt_d       = '0;
            last_d      = 1'b0;
          end
          if (!idx_last) begin
            idx_d     = idx_q + IdxW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + IdxW'(1);
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_REPORT;
          subj_d      = '0;
          nxt_d       = any_q ? next_q : default_q;
          last_d      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      any_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      any_q       <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    next_q <= next_d;
    kind_q <= kind_d;
    subj_q <= subj_d;
    nxt_q  <= nxt_d;
    last_q <= last_d;
  end

  mctu_ram #(
    .WIDTH(PERIOD_W),
    .DEPTH(CHANNELS)
  ) u_period_ram (
    .clk_i  (clk_i),
    .we_i   (per_we),
    .waddr_i(subj_idx),
    .wdata_i(interval_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(per_rd)
  );

  mctu_ram #(
    .WIDTH(TIME_WIDTH),
    .DEPTH(CHANNELS)
  ) u_last_fire_ram (
    .clk_i  (clk_i),
    .we_i   (lft_we),
    .waddr_i(lft_waddr),
    .wdata_i(lft_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(lft_rd)
  );

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign subject_res_o   = subj_q;
  assign wake_interval_o = nxt_q;
  assign last_o          = last_q;

  `MCTU_ASSERT_NOW(a_last_is_report, out_valid_o && last_o, kind_o == KIND_REPORT)
  `MCTU_ASSERT_NEXT(a_tick_starts_scan, in_fire && mode_i == MODE_TICK, state_q == ST_SCAN)
  `MCTU_ASSERT_NEXT(a_report_loaded, state_q == ST_REPORT && out_free, out_valid_o && last_o)
  `MCTU_ASSERT_NEXT(a_scan_holds_on_stall, state_q == ST_SCAN && !step, $stable(idx_q))

endmodule

// ===== rtl/mctu_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module mctu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
